/* rtl/servo_command_line_parser_top_defines.svh */
// Assertion helpers for the parser RTL.
// Both sample on aclk and stand down while aresetn is low.
`ifndef SERVO_COMMAND_LINE_PARSER_TOP_DEFINES_SVH
`define SERVO_COMMAND_LINE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication.
`define SCP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/scp_pkg.sv */
package scp_pkg;

    localparam int LINE_DEPTH = 6;
    localparam int POS_W      = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

    localparam int BYTE_W     = 8;
    localparam int CENTER_W   = 15;
    localparam int BOUND_W    = 12;
    localparam int VAL_W      = 18;
    localparam int MAG_W      = 18;
    localparam int PULSE_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int DIGIT_W    = 4;
    localparam int MAC_A_W    = 18;
    localparam int MAC_B_W    = 16;
    localparam int MAC_P_W    = MAC_A_W + MAC_B_W;
    localparam int RES_W      = STATUS_W + 1 + VAL_W + 2 * PULSE_W;
    localparam int TDATA_W    = ((RES_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_X     = 8'h78;
    localparam logic [BYTE_W-1:0] CH_Y     = 8'h79;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADSEL = 2'd2;

    localparam logic CHAN_A = 1'b0;
    localparam logic CHAN_B = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B_MIN    = 3'd4;

    localparam logic [CENTER_W-1:0] CENTER_A_RST = 15'd1370;
    localparam logic [BOUND_W-1:0]  A_MAX_RST    = 12'd900;
    localparam logic [BOUND_W-1:0]  A_MIN_RST    = 12'd0;
    localparam logic [BOUND_W-1:0]  B_MAX_RST    = 12'd800;
    localparam logic [BOUND_W-1:0]  B_MIN_RST    = 12'd0;
    localparam logic [PULSE_W-1:0]  CMP_A_RST    = 16'd1370;
    localparam logic [PULSE_W-1:0]  CMP_B_RST    = 16'd2250;

    localparam logic [MAG_W-1:0]   MAG_SAT     = 18'd200000;
    localparam logic [MAG_W-1:0]   POS_LIMIT   = 18'd131071;
    localparam logic [MAG_W-1:0]   NEG_LIMIT   = 18'd131072;
    localparam logic [MAC_B_W-1:0] DEC_BASE    = 16'd10;
    localparam logic [MAC_B_W-1:0] RECIP10     = 16'd52429;
    localparam int                 RECIP_SHIFT = 19;
    localparam logic signed [VAL_W+2:0] A_BASE = 21'sd150;
    localparam logic [PULSE_W-1:0] A_SUB       = 16'd450;
    localparam logic [PULSE_W-1:0] B_BASE      = 16'd2250;

    typedef struct packed {
        logic [CENTER_W-1:0] center_a;
        logic [BOUND_W-1:0]  a_max;
        logic [BOUND_W-1:0]  a_min;
        logic [BOUND_W-1:0]  b_max;
        logic [BOUND_W-1:0]  b_min;
    } cfg_t;

    typedef struct packed {
        logic wr_en;
        logic clear;
    } buf_ctl_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   channel;
        logic signed [VAL_W-1:0] parsed_value;
        logic [PULSE_W-1:0]     pulse_a;
        logic [PULSE_W-1:0]     pulse_b;
    } res_t;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

/* rtl/scp_mac.sv */
module scp_mac (
    input  logic [scp_pkg::MAC_A_W-1:0]   op_a,
    input  logic [scp_pkg::MAC_B_W-1:0]   op_b,
    input  logic [scp_pkg::DIGIT_W-1:0]   op_c,
    output logic [scp_pkg::MAC_P_W-1:0]   prod
);

    // Shared multiply-add: decimal accumulate and reciprocal divide
    assign prod = scp_pkg::MAC_P_W'(op_a) * scp_pkg::MAC_P_W'(op_b)
                + scp_pkg::MAC_P_W'(op_c);

endmodule

/* rtl/scp_line_buf.sv */
module scp_line_buf (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  scp_pkg::buf_ctl_t           ctl,
    input  logic [scp_pkg::BYTE_W-1:0]  wr_byte,
    input  logic [scp_pkg::POS_W-1:0]   rd_addr,
    output logic [scp_pkg::BYTE_W-1:0]  rd_byte,
    output logic [scp_pkg::BYTE_W-1:0]  sel_byte
);

    logic [scp_pkg::BYTE_W-1:0] store_reg [scp_pkg::LINE_DEPTH];
    logic [scp_pkg::POS_W-1:0]  pos_reg;
    logic [scp_pkg::POS_W-1:0]  pos_next;

    // Wrap after the last slot
    always_comb begin
        if (pos_reg == scp_pkg::POS_W'(scp_pkg::LINE_DEPTH - 1)) begin
            pos_next = '0;
        end else begin
            pos_next = pos_reg + scp_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            for (int i = 0; i < scp_pkg::LINE_DEPTH; i++) begin
                store_reg[i] <= '0;
            end
            pos_reg <= '0;
        end else if (ctl.wr_en) begin
            store_reg[pos_reg] <= wr_byte;
            pos_reg            <= pos_next;
        end
    end

    assign rd_byte  = store_reg[rd_addr];
    assign sel_byte = store_reg[0];

endmodule

/* rtl/scp_ctrl.sv */
`include "servo_command_line_parser_top_defines.svh"

module scp_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic [scp_pkg::BYTE_W-1:0]  in_byte,
    output logic                        s_tready,
    output scp_pkg::buf_ctl_t           buf_ctl,
    output logic [scp_pkg::POS_W-1:0]   rd_addr,
    input  logic [scp_pkg::BYTE_W-1:0]  rd_byte,
    input  logic [scp_pkg::BYTE_W-1:0]  sel_byte,
    input  scp_pkg::cfg_t               cfg,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output scp_pkg::res_t               res
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SEL  = 7'b0000010,
        ST_SCAN = 7'b0000100,
        ST_SIGN = 7'b0001000,
        ST_MAP  = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        PH_SPACE = 3'b001,
        PH_DIGIT = 3'b010,
        PH_STOP  = 3'b100
    } phase_t;

    state_t                              state_reg,  state_next;
    phase_t                              phase_reg,  phase_next;
    logic [scp_pkg::CNT_W-1:0]           idx_reg,    idx_next;
    logic                                neg_reg,    neg_next;
    logic [scp_pkg::MAG_W-1:0]           mag_reg,    mag_next;
    logic signed [scp_pkg::VAL_W-1:0]    val_reg,    val_next;
    logic                                chan_reg,   chan_next;
    logic [scp_pkg::STATUS_W-1:0]        status_reg, status_next;
    logic [scp_pkg::PULSE_W-1:0]         quot_reg,   quot_next;
    logic [scp_pkg::PULSE_W-1:0]         cmp_a_reg,  cmp_a_next;
    logic [scp_pkg::PULSE_W-1:0]         cmp_b_reg,  cmp_b_next;
    logic                                m_valid_reg, m_valid_next;
    scp_pkg::res_t                       res_reg,    res_next;

    logic [scp_pkg::MAC_A_W-1:0]         mac_a;
    logic [scp_pkg::MAC_B_W-1:0]         mac_b;
    logic [scp_pkg::DIGIT_W-1:0]         mac_c;
    logic [scp_pkg::MAC_P_W-1:0]         mac_p;
    logic [scp_pkg::MAG_W-1:0]           mac_sat;

    logic                                is_digit;
    logic                                scan_end;
    logic signed [scp_pkg::VAL_W+2:0]    a_val;
    logic signed [scp_pkg::VAL_W+1:0]    b_val;
    logic                                a_ok;
    logic                                b_ok;
    logic [scp_pkg::PULSE_W-1:0]         new_a;

    scp_mac u_mac (
        .op_a (mac_a),
        .op_b (mac_b),
        .op_c (mac_c),
        .prod (mac_p)
    );

    assign rd_addr  = idx_reg[scp_pkg::POS_W-1:0];
    assign is_digit = (rd_byte >= scp_pkg::CH_ZERO) && (rd_byte <= scp_pkg::CH_NINE);
    assign scan_end = (idx_reg == scp_pkg::CNT_W'(scp_pkg::LINE_DEPTH))
                   || (rd_byte == scp_pkg::CH_NUL) || (rd_byte == scp_pkg::CH_CR)
                   || (phase_reg == PH_STOP);

    // Multiply-add operand select: divide by ten while mapping, else accumulate
    always_comb begin
        if (state_reg == ST_MAP) begin
            mac_a = {2'b00, val_reg[9:0], 6'b000000};
            mac_b = scp_pkg::RECIP10;
            mac_c = '0;
        end else begin
            mac_a = mag_reg;
            mac_b = scp_pkg::DEC_BASE;
            mac_c = scp_pkg::DIGIT_W'(rd_byte - scp_pkg::CH_ZERO);
        end
    end

    assign mac_sat = (mac_p > scp_pkg::MAC_P_W'(scp_pkg::MAG_SAT)) ? scp_pkg::MAG_SAT
                                                                    : mac_p[scp_pkg::MAG_W-1:0];

    assign a_val = $signed({val_reg[scp_pkg::VAL_W-1], val_reg, 2'b00}) + scp_pkg::A_BASE;
    assign b_val = $signed({val_reg, 2'b00});
    assign a_ok  = (a_val >= $signed({9'b0, cfg.a_min})) && (a_val <= $signed({9'b0, cfg.a_max}));
    assign b_ok  = (b_val >= $signed({8'b0, cfg.b_min})) && (b_val <= $signed({8'b0, cfg.b_max}));
    assign new_a = scp_pkg::PULSE_W'(cfg.center_a) + a_val[scp_pkg::PULSE_W-1:0] - scp_pkg::A_SUB;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        val_next     = val_reg;
        chan_next    = chan_reg;
        status_next  = status_reg;
        quot_next    = quot_reg;
        cmp_a_next   = cmp_a_reg;
        cmp_b_next   = cmp_b_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = 1'b0;
        buf_ctl      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                buf_ctl.wr_en = s_tvalid;
                if (s_tvalid && in_byte == scp_pkg::CH_LF) begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL: begin
                idx_next   = scp_pkg::CNT_W'(1);
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                mag_next   = '0;
                if (sel_byte == scp_pkg::CH_X) begin
                    chan_next  = scp_pkg::CHAN_A;
                    state_next = ST_SCAN;
                end else if (sel_byte == scp_pkg::CH_Y) begin
                    chan_next  = scp_pkg::CHAN_B;
                    state_next = ST_SCAN;
                end else begin
                    chan_next   = scp_pkg::CHAN_A;
                    val_next    = '0;
                    status_next = scp_pkg::STATUS_BADSEL;
                    state_next  = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_SIGN;
                end else begin
                    idx_next = idx_reg + scp_pkg::CNT_W'(1);
                    unique case (phase_reg)
                        PH_SPACE: begin
                            if (scp_pkg::is_space(rd_byte)) begin
                                phase_next = PH_SPACE;
                            end else if (rd_byte == scp_pkg::CH_PLUS
                                      || rd_byte == scp_pkg::CH_MINUS) begin
                                neg_next   = (rd_byte == scp_pkg::CH_MINUS);
                                phase_next = PH_DIGIT;
                            end else if (is_digit) begin
                                mag_next   = mac_sat;
                                phase_next = PH_DIGIT;
                            end else begin
                                phase_next = PH_STOP;
                            end
                        end
                        PH_DIGIT: begin
                            if (is_digit) begin
                                mag_next = mac_sat;
                            end else begin
                                phase_next = PH_STOP;
                            end
                        end
                        default: begin
                            phase_next = PH_STOP;
                        end
                    endcase
                end
            end
            ST_SIGN: begin
                if (neg_reg) begin
                    if (mag_reg > scp_pkg::NEG_LIMIT) begin
                        val_next = $signed(~scp_pkg::NEG_LIMIT + scp_pkg::MAG_W'(1));
                    end else begin
                        val_next = $signed(~mag_reg + scp_pkg::MAG_W'(1));
                    end
                end else if (mag_reg > scp_pkg::POS_LIMIT) begin
                    val_next = $signed(scp_pkg::POS_LIMIT);
                end else begin
                    val_next = $signed(mag_reg);
                end
                state_next = ST_MAP;
            end
            ST_MAP: begin
                if (chan_reg == scp_pkg::CHAN_A) begin
                    if (a_ok) begin
                        cmp_a_next  = new_a;
                        status_next = scp_pkg::STATUS_OK;
                    end else begin
                        status_next = scp_pkg::STATUS_RANGE;
                    end
                    state_next = ST_DONE;
                end else if (b_ok) begin
                    quot_next   = scp_pkg::PULSE_W'(mac_p >> scp_pkg::RECIP_SHIFT);
                    status_next = scp_pkg::STATUS_OK;
                    state_next  = ST_DIV;
                end else begin
                    status_next = scp_pkg::STATUS_RANGE;
                    state_next  = ST_DONE;
                end
            end
            ST_DIV: begin
                cmp_b_next = scp_pkg::B_BASE - quot_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    res_next.status       = status_reg;
                    res_next.channel      = chan_reg;
                    res_next.parsed_value = val_reg;
                    res_next.pulse_a      = cmp_a_reg;
                    res_next.pulse_b      = cmp_b_reg;
                    m_valid_next          = 1'b1;
                    buf_ctl.clear         = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_SPACE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            cmp_a_reg   <= scp_pkg::CMP_A_RST;
            cmp_b_reg   <= scp_pkg::CMP_B_RST;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            cmp_a_reg   <= cmp_a_next;
            cmp_b_reg   <= cmp_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        val_reg    <= val_next;
        chan_reg   <= chan_next;
        status_reg <= status_next;
        quot_reg   <= quot_next;
        res_reg    <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign res      = res_reg;

    `SCP_ASSERT_NXT(a_lf_starts_parse, s_tvalid && s_tready && in_byte == scp_pkg::CH_LF, state_reg == ST_SEL, "newline item did not start a parse")
    `SCP_ASSERT_NXT(a_cmp_a_hold, state_reg != ST_MAP, $stable(cmp_a_reg), "servo A compare moved outside mapping")
    `SCP_ASSERT_IMP(a_idx_bound, state_reg == ST_SCAN, idx_reg <= scp_pkg::LINE_DEPTH, "scan index ran past the line")
    `SCP_ASSERT_IMP(a_badsel_zero, m_valid_reg && res_reg.status == scp_pkg::STATUS_BADSEL, res_reg.parsed_value == '0 && res_reg.channel == scp_pkg::CHAN_A, "bad selector result carries data")

endmodule

/* rtl/servo_command_line_parser_top.sv */
// Servo command line parser. Bytes from a serial receiver enter on the s_ stream one at a time
// into a six-byte line ring. A newline starts a parse of the line ("x<num>" drives servo A,
// "y<num>" servo B), after which one result item leaves on the m_ stream with the status,
// the channel, the converted number and both compare values. The parse walks the line one
// character per cycle through a single shared multiply-add unit, which also does the divide
// by ten for servo B; the next byte is not accepted until the parse is done and its result
// has moved into the result register. Configuration writes on the cfg_ port are registered
// and must be made while no line is being parsed.
module servo_command_line_parser_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [scp_pkg::BYTE_W-1:0]        s_tdata,    // [7:0] rx_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] status, [2] channel, [20:3] parsed_value, [36:21] pulse_a, [52:37] pulse_b
    output logic [scp_pkg::TDATA_W-1:0]       m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    scp_pkg::cfg_t                   cfg_reg;
    scp_pkg::buf_ctl_t               buf_ctl;
    logic [scp_pkg::POS_W-1:0]       rd_addr;
    logic [scp_pkg::BYTE_W-1:0]      rd_byte;
    logic [scp_pkg::BYTE_W-1:0]      sel_byte;
    scp_pkg::res_t                   res;

    assign cfg_ready = 1'b1;

    // Unknown register indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_a <= scp_pkg::CENTER_A_RST;
            cfg_reg.a_max    <= scp_pkg::A_MAX_RST;
            cfg_reg.a_min    <= scp_pkg::A_MIN_RST;
            cfg_reg.b_max    <= scp_pkg::B_MAX_RST;
            cfg_reg.b_min    <= scp_pkg::B_MIN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                scp_pkg::REG_CENTER_A: cfg_reg.center_a <= cfg_data;
                scp_pkg::REG_A_MAX:    cfg_reg.a_max    <= cfg_data[scp_pkg::BOUND_W-1:0];
                scp_pkg::REG_A_MIN:    cfg_reg.a_min    <= cfg_data[scp_pkg::BOUND_W-1:0];
                scp_pkg::REG_B_MAX:    cfg_reg.b_max    <= cfg_data[scp_pkg::BOUND_W-1:0];
                scp_pkg::REG_B_MIN:    cfg_reg.b_min    <= cfg_data[scp_pkg::BOUND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    scp_line_buf u_line_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (buf_ctl),
        .wr_byte  (s_tdata),
        .rd_addr  (rd_addr),
        .rd_byte  (rd_byte),
        .sel_byte (sel_byte)
    );

    scp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_byte  (s_tdata),
        .s_tready (s_tready),
        .buf_ctl  (buf_ctl),
        .rd_addr  (rd_addr),
        .rd_byte  (rd_byte),
        .sel_byte (sel_byte),
        .cfg      (cfg_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res      (res)
    );

    assign m_tdata = {{(scp_pkg::TDATA_W - scp_pkg::RES_W){1'b0}},
                      res.pulse_b, res.pulse_a, res.parsed_value, res.channel, res.status};

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import scp_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    servo_command_line_parser_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Line parser state as seen from outside
    logic [BYTE_W-1:0]   line_buf [LINE_DEPTH];
    int unsigned         line_pos;
    logic [PULSE_W-1:0]  cmp_a_q;
    logic [PULSE_W-1:0]  cmp_b_q;
    logic [CENTER_W-1:0] center_q;
    logic [BOUND_W-1:0]  a_max_q;
    logic [BOUND_W-1:0]  a_min_q;
    logic [BOUND_W-1:0]  b_max_q;
    logic [BOUND_W-1:0]  b_min_q;

    res_t command_reports [$];
    int   mismatches = 0;
    int   rx_bytes_sent = 0;
    int   send_idle_pct = 32;
    int   recv_idle_pct = 73;
    int   hold_request = 0;
    int   hold_left = 0;
    int   stall_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void reset_model();
        foreach (line_buf[i]) line_buf[i] = CH_NUL;
        line_pos = 0;
        cmp_a_q  = 16'd1370;
        cmp_b_q  = 16'd2250;
        center_q = 15'd1370;
        a_max_q  = 12'd900;
        a_min_q  = 12'd0;
        b_max_q  = 12'd800;
        b_min_q  = 12'd0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_CENTER_A: center_q = val[CENTER_W-1:0];
            REG_A_MAX:    a_max_q  = val[BOUND_W-1:0];
            REG_A_MIN:    a_min_q  = val[BOUND_W-1:0];
            REG_B_MAX:    b_max_q  = val[BOUND_W-1:0];
            REG_B_MIN:    b_min_q  = val[BOUND_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic bit blank_char(input logic [BYTE_W-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Decimal conversion of the bytes after the selector
    function automatic longint line_value();
        logic [BYTE_W-1:0] chars [$];
        int     i;
        int     k;
        bit     neg;
        longint mag;
        i = 1;
        k = 0;
        neg = 1'b0;
        mag = 0;
        while (i < LINE_DEPTH && line_buf[i] != CH_NUL && line_buf[i] != CH_CR) begin
            chars.push_back(line_buf[i]);
            i++;
        end
        while (k < chars.size() && blank_char(chars[k]))
            k++;
        if (k < chars.size() && (chars[k] == CH_PLUS || chars[k] == CH_MINUS)) begin
            neg = (chars[k] == CH_MINUS);
            k++;
        end
        while (k < chars.size() && chars[k] >= CH_ZERO && chars[k] <= CH_NINE) begin
            mag = mag * 10 + longint'(chars[k] - CH_ZERO);
            if (mag > 200000)
                mag = 200000;
            k++;
        end
        if (neg)
            mag = -mag;
        if (mag > 131071)
            mag = 131071;
        if (mag < -131072)
            mag = -131072;
        return mag;
    endfunction

    // Store one received byte; on a newline work out the status report
    function automatic bit predict_rx_byte(input logic [BYTE_W-1:0] c, output res_t rep);
        longint v;
        longint ang;
        longint t;
        line_buf[line_pos] = c;
        line_pos = (line_pos == LINE_DEPTH - 1) ? 0 : line_pos + 1;
        if (c != CH_LF)
            return 1'b0;
        rep.status  = STATUS_BADSEL;
        rep.channel = CHAN_A;
        v = 0;
        if (line_buf[0] == CH_X) begin
            v = line_value();
            ang = 150 + 4 * v;
            rep.status = STATUS_RANGE;
            if (ang >= longint'(a_min_q) && ang <= longint'(a_max_q)) begin
                t = longint'(center_q) + ang - 450;
                cmp_a_q = t[PULSE_W-1:0];
                rep.status = STATUS_OK;
            end
        end else if (line_buf[0] == CH_Y) begin
            v = line_value();
            ang = 4 * v;
            rep.channel = CHAN_B;
            rep.status = STATUS_RANGE;
            if (ang >= longint'(b_min_q) && ang <= longint'(b_max_q)) begin
                t = 2250 - (ang * 16) / 10;
                cmp_b_q = t[PULSE_W-1:0];
                rep.status = STATUS_OK;
            end
        end
        foreach (line_buf[i]) line_buf[i] = CH_NUL;
        line_pos = 0;
        rep.parsed_value = v[VAL_W-1:0];
        rep.pulse_a = cmp_a_q;
        rep.pulse_b = cmp_b_q;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        res_t rep;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        if (predict_rx_byte(b, rep))
            command_reports.push_back(rep);
        rx_bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_command(input string body);
        send_text(body);
        send_byte(CH_LF);
    endtask

    // Mostly well-formed commands with random content, some noise and broken lines
    task automatic send_line();
        logic [BYTE_W-1:0] text [$];
        logic [BYTE_W-1:0] rnd;
        string digits;
        int    pick;
        int    v;
        int    i;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 9)) begin
                rnd = BYTE_W'($urandom_range(255));
                text.push_back(rnd);
            end
        end else begin
            rnd = BYTE_W'($urandom_range(255));
            if (pick < 52)
                text.push_back(CH_X);
            else if (pick < 95)
                text.push_back(CH_Y);
            else
                text.push_back(rnd);
            if ($urandom_range(4) == 0)
                text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            if ($urandom_range(3) == 0)
                v = int'($urandom_range(19998)) - 9999;
            else
                v = int'($urandom_range(1100)) - 60;
            if (v < 0)
                text.push_back(CH_MINUS);
            else if ($urandom_range(9) == 0)
                text.push_back(CH_PLUS);
            digits = $sformatf("%0d", (v < 0) ? -v : v);
            for (i = 0; i < digits.len(); i++)
                text.push_back(digits[i]);
            if ($urandom_range(9) == 0) begin
                text.push_back(CH_CR);
                rnd = BYTE_W'($urandom_range(255));
                text.push_back(rnd);
            end
            // leave the odd line unterminated so the next one runs on
            if ($urandom_range(29) != 0)
                text.push_back(CH_LF);
        end
        foreach (text[j]) send_byte(text[j]);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_register(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold the input, wait for every report, then let the parse walk settle
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (command_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic randomize_registers();
        int lo;
        write_register(REG_CENTER_A, CFG_DATA_W'($urandom_range(20000)));
        lo = $urandom_range(700);
        write_register(REG_A_MIN, CFG_DATA_W'(lo));
        write_register(REG_A_MAX, CFG_DATA_W'(lo + $urandom_range(3395)));
        lo = $urandom_range(700);
        write_register(REG_B_MIN, CFG_DATA_W'(lo));
        write_register(REG_B_MAX, CFG_DATA_W'(lo + $urandom_range(3395)));
        // now and then swap the servo B bounds round
        if ($urandom_range(4) == 0) begin
            write_register(REG_B_MIN, CFG_DATA_W'(3000 + $urandom_range(1095)));
            write_register(REG_B_MAX, CFG_DATA_W'($urandom_range(2999)));
        end
    endtask

    task automatic test_directed_commands();
        send_command("x");
        send_command("y-1");
        send_command("x+200");
        send_byte(8'hFF);
        send_byte(CH_NUL);
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_text("x 1");
        send_byte(CH_CR);
        send_command("9");
        send_command("x12345");
        drain_results();
    endtask

    task automatic test_register_extremes();
        write_register(REG_CENTER_A, 15'd0);
        write_register(REG_A_MAX, 15'd4095);
        write_register(REG_A_MIN, 15'd0);
        write_register(REG_B_MAX, 15'd4095);
        write_register(REG_B_MIN, 15'd0);
        // unmapped indexes must leave every register alone
        write_register(REG_SPARE_LO, '1);
        write_register(REG_SPARE_HI, '1);
        send_command("x0");
        send_command("y1023");
        repeat (8) send_line();
        drain_results();

        write_register(REG_CENTER_A, 15'd20000);
        write_register(REG_A_MAX, 15'd0);
        write_register(REG_A_MIN, 15'd4095);
        write_register(REG_B_MAX, 15'd0);
        write_register(REG_B_MIN, 15'd4095);
        repeat (6) send_line();
        drain_results();

        write_register(REG_CENTER_A, '1);
        write_register(REG_A_MAX, '1);
        write_register(REG_A_MIN, '1);
        write_register(REG_B_MAX, '1);
        write_register(REG_B_MIN, '1);
        repeat (4) send_line();
        drain_results();

        write_register(REG_A_MIN, 15'd550);
        write_register(REG_A_MAX, 15'd550);
        write_register(REG_B_MIN, 15'd400);
        write_register(REG_B_MAX, 15'd400);
        send_command("x100");
        send_command("y100");
        repeat (4) send_line();
        drain_results();
    endtask

    task automatic test_random_traffic();
        int phase;
        int start;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 32;
                    recv_idle_pct = 73;
                end
                1: begin
                    send_idle_pct = 73;
                    recv_idle_pct = 32;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            randomize_registers();
            start = rx_bytes_sent;
            while (rx_bytes_sent - start < 210)
                send_line();
            drain_results();
        end
    endtask

    // Keep offering commands while the report side is held off
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 400;
        repeat (12) send_line();
        drain_results();
    endtask

    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : report_check
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (command_reports.size() == 0) begin
                $error("report item with no newline pending");
                mismatches++;
            end else begin
                want = command_reports.pop_front();
                check_field("status", want.status, m_tdata[1:0]);
                check_field("channel", want.channel, m_tdata[2]);
                check_field("parsed_value", want.parsed_value, $signed(m_tdata[20:3]));
                check_field("pulse_a", want.pulse_a, m_tdata[36:21]);
                check_field("pulse_b", want.pulse_b, m_tdata[52:37]);
                check_field("padding", 0, m_tdata[TDATA_W-1:RES_W]);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        reset_model();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_commands();
        test_register_extremes();
        test_random_traffic();
        test_output_stall();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
